// ----- hdl/olst_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the ordered list store.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package olst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int FIELD_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic              load;
    logic              do_insert;
    logic              rd_en;
    logic              shift_en;
    logic              dec_count;
    logic              set_res;
    logic [STAT_W-1:0] res_status;
    logic              res_pos;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            count_zero;
    logic            count_full;
    logic            rvalid;
    logic            match;
    logic            last;
    logic            out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/olst_ctrl.sv -----
// Controller state machine of the ordered list store: dispatch, scan, shift and result hand-off.
// Depends on olst_pkg for the command and status types and the operation and status codes.
`default_nettype none

module olst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire olst_pkg::sts_t sts,
  output olst_pkg::cmd_t     cmd
);
  import olst_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_INSERT: begin
            cmd.set_res = 1'b1;
            if (sts.count_full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.do_insert = 1'b1;
            end
            state_next = S_DONE;
          end
          OP_DELETE, OP_LOOKUP: begin
            if (sts.count_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_next     = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_SCAN;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
            state_next  = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.rvalid) begin
          if (sts.match) begin
            if (sts.op == OP_LOOKUP) begin
              cmd.set_res = 1'b1;
              cmd.res_pos = 1'b1;
              state_next  = S_DONE;
            end else begin
              state_next = S_SHIFT;
            end
          end else if (sts.last) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            state_next     = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        cmd.rd_en    = 1'b1;
        cmd.shift_en = 1'b1;
        if (!sts.rvalid) begin
          cmd.dec_count = 1'b1;
          cmd.set_res   = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/olst_dp.sv -----
// Datapath of the ordered list store: entry memory, count, read stream, result and output registers.
// Depends on olst_pkg; driven by commands from olst_ctrl.
`default_nettype none

module olst_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire olst_pkg::cmd_t                       cmd,
  output olst_pkg::sts_t                            sts,
  input  wire logic [olst_pkg::OP_W-1:0]            in_op,
  input  wire logic signed [olst_pkg::VALUE_W-1:0]  in_value,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic [olst_pkg::STAT_W-1:0]               out_status,
  output logic [olst_pkg::FIELD_W-1:0]              out_pos,
  output logic [olst_pkg::FIELD_W-1:0]              out_len,
  output logic                                      out_empty
);
  import olst_pkg::*;

  logic [VALUE_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]   count;
  logic [OP_W-1:0]    op_r;
  logic [VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]   rptr;
  logic [IDX_W-1:0]   cidx;
  logic               rvalid;
  logic [VALUE_W-1:0] rdata;
  logic [STAT_W-1:0]  res_status;
  logic [CNT_W-1:0]   res_pos;

  logic               rd_go;
  logic               wen;
  logic [IDX_W-1:0]   waddr;
  logic [VALUE_W-1:0] wdata;

  assign rd_go = cmd.rd_en && (rptr < count);
  assign wen   = cmd.do_insert || (cmd.shift_en && rvalid);
  assign waddr = cmd.do_insert ? count[IDX_W-1:0] : (cidx - IDX_W'(1));
  assign wdata = cmd.do_insert ? value_r : rdata;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (rd_go) begin
      rdata <= mem[rptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rvalid    <= 1'b0;
      rptr      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.do_insert) begin
        count <= count + CNT_W'(1);
      end else if (cmd.dec_count) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.load) begin
        rptr   <= '0;
        rvalid <= 1'b0;
      end else begin
        rvalid <= rd_go;
        if (rd_go) begin
          rptr <= rptr + CNT_W'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      value_r <= in_value;
    end
    if (rd_go) begin
      cidx <= rptr[IDX_W-1:0];
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_pos    <= cmd.res_pos ? (CNT_W'(cidx) + CNT_W'(1)) : '0;
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_pos    <= FIELD_W'(res_pos);
      out_len    <= FIELD_W'(count);
      out_empty  <= (count == '0);
    end
  end

  assign sts.op         = op_r;
  assign sts.count_zero = (count == '0);
  assign sts.count_full = (count >= CNT_W'(CAPACITY));
  assign sts.rvalid     = rvalid;
  assign sts.match      = rvalid && (rdata == value_r);
  assign sts.last       = (CNT_W'(cidx) == (count - CNT_W'(1)));
  assign sts.out_free   = !out_valid || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the count by one");

  a_no_dec_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.dec_count |-> (count != '0))
    else $error("delete completed on an empty list");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

// ----- hdl/ordered_list_store.sv -----
// Flow: insert, full, empty and undefined operations go from dispatch to the result hand-off;
// lookup and delete first walk the entries one per cycle, and a delete then shifts the rest down.
// Throughput: one item at a time, taken only while the controller is idle; the next item
// is accepted the cycle after a result is registered, even while that result is still waiting.
// Reset (rst, synchronous, active high) empties the list at once; entry contents are not cleared.
// Top level of the ordered list store; depends on olst_pkg, olst_ctrl and olst_dp.
`default_nettype none

module ordered_list_store (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [1:0] status, [6:2] position, [11:7] length,
                                           // [12] is_empty, [15:13] zero
);
  import olst_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [STAT_W-1:0]  out_status;
  logic [FIELD_W-1:0] out_pos;
  logic [FIELD_W-1:0] out_len;
  logic               out_empty;

  olst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  olst_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_axis_tuser),
    .in_value   (s_axis_tdata),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (out_status),
    .out_pos    (out_pos),
    .out_len    (out_len),
    .out_empty  (out_empty)
  );

  assign m_axis_tdata = {3'b000, out_empty, out_len, out_pos, out_status};

endmodule

`default_nettype wire

// ----- tb/ordered_list_store_tb.sv -----
// Self-checking testbench for ordered_list_store: directed and random insert, delete, lookup and
// undefined items, each result checked field by field against a scoreboard that tracks the list contents.
// Depends on olst_pkg and the ordered_list_store RTL.
`default_nettype none

module ordered_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int SEGMENTS    = 12;
  localparam int SEG_ITEMS   = 50;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] length;
    logic               is_empty;
  } list_result_t;

  class list_scoreboard;
    logic [VALUE_W-1:0] stored [CAPACITY];
    int unsigned used;
    list_result_t expected_q[$];
    int errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
      list_result_t r;
      int hit;
      r = '0;
      r.status = ST_OK;
      hit = -1;
      for (int i = 0; i < used; i++) begin
        if (hit < 0 && stored[i] == val) hit = i;
      end
      case (op)
        OP_INSERT: begin
          if (used >= CAPACITY) r.status = ST_FULL;
          else begin
            stored[used] = val;
            used++;
          end
        end
        OP_DELETE: begin
          if (used == 0) r.status = ST_EMPTY;
          else if (hit < 0) r.status = ST_NOT_FOUND;
          else begin
            for (int i = hit; i + 1 < used; i++) stored[i] = stored[i + 1];
            used--;
          end
        end
        OP_LOOKUP: begin
          if (used == 0) r.status = ST_EMPTY;
          else if (hit < 0) r.status = ST_NOT_FOUND;
          else r.position = FIELD_W'(hit + 1);
        end
        default: ;
      endcase
      r.length = FIELD_W'(used);
      r.is_empty = (used == 0);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [15:0] data);
      list_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result %h arrived with no item outstanding", $time, data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 32'(want.status), 32'(data[1:0]));
      compare_field("position", 32'(want.position), 32'(data[6:2]));
      compare_field("length", 32'(want.length), 32'(data[11:7]));
      compare_field("is_empty", 32'(want.is_empty), 32'(data[12]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  list_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_len = 0;
  int quiet_cycles = 0;
  logic [VALUE_W-1:0] value_pool [8];

  ordered_list_store dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst) quiet_cycles = 0;
    else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser, s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else quiet_cycles++;
    end
  end

  // The receiver either holds off for a requested stretch, stalls in short bursts, or accepts.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
        m_axis_tready <= 1'b1;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= val;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  initial begin
    int ins_pct;
    int r;
    logic [OP_W-1:0] op;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_pct = 20;
    rx_idle_pct = 20;

    send_item(OP_LOOKUP, 32'h0000_0005);
    send_item(OP_DELETE, 32'h0000_0005);
    send_item(OP_UNDEF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    for (int i = 5; i < CAPACITY; i++) send_item(OP_INSERT, 32'(32'h100 + i));
    send_item(OP_INSERT, 32'h1234_5678);
    send_item(OP_LOOKUP, 32'(32'h100 + CAPACITY - 1));
    send_item(OP_LOOKUP, 32'h7FFF_FFFF);
    send_item(OP_DELETE, 32'h7FFF_FFFF);
    send_item(OP_LOOKUP, 32'h7FFF_FFFF);
    send_item(OP_DELETE, 32'(32'h100 + CAPACITY - 1));
    send_item(OP_DELETE, 32'h5555_AAAA);
    send_item(OP_LOOKUP, 32'h5555_AAAA);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      for (int k = 2; k < 8; k++) begin
        value_pool[k] = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 15));
      end
      ins_pct = $urandom_range(15, 80);
      if (seg == SEGMENTS - 1) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (seg == 6) begin
        tx_idle_pct = 0;
        rx_hold_len = 80;
      end else begin
        tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (seg == 3 || $urandom_range(0, 3) == 0) drain_results();
      for (int n = 0; n < SEG_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 5) op = OP_UNDEF;
        else if (r < 5 + ins_pct) op = OP_INSERT;
        else op = $urandom_range(0, 1) ? OP_DELETE : OP_LOOKUP;
        send_item(op, pick_value());
      end
    end

    drain_results();
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
